// ===== sv/cstc_pkg.sv =====
// ----------------------------------------------------------------------------
// Case-swap columnar transposition package
// Shared types, register indexes, control-store layout and helper functions.
// ----------------------------------------------------------------------------
package cstc_pkg;

   localparam int MAX_MESSAGE_DEF = 32;
   localparam int MAX_KEY_DEF     = 16;

   localparam logic [7:0] PAD_CHAR     = 8'h20;
   localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int KEY_LEN_W   = 5;
   localparam int CHARS_PER_WORD = 4;

   localparam logic [CSR_INDEX_W-1:0] REG_KEY_LENGTH    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_KEY_CHARS_0_3 = 3'd1;

   typedef struct packed {
      logic [7:0] message_byte;
      logic       message_end;
   } cstc_req_type;

   typedef struct packed {
      logic [7:0] cipher_byte;
      logic       run_end;
      logic       overflowed;
   } cstc_rsp_type;

   // Control store layout.
   localparam int PC_W = 3;

   localparam logic [PC_W-1:0] ST_LOAD      = 3'd0;
   localparam logic [PC_W-1:0] ST_SCAN_INIT = 3'd1;
   localparam logic [PC_W-1:0] ST_SCAN      = 3'd2;
   localparam logic [PC_W-1:0] ST_MARK      = 3'd3;
   localparam logic [PC_W-1:0] ST_READ      = 3'd4;
   localparam logic [PC_W-1:0] ST_SEND      = 3'd5;
   localparam logic [PC_W-1:0] ST_RANK      = 3'd6;
   localparam logic [PC_W-1:0] ST_DONE      = 3'd7;

   localparam logic [1:0] WAIT_NONE = 2'd0;
   localparam logic [1:0] WAIT_REQ  = 2'd1;
   localparam logic [1:0] WAIT_RSP  = 2'd2;

   localparam logic [2:0] COND_ALWAYS    = 3'd0;
   localparam logic [2:0] COND_START     = 3'd1;
   localparam logic [2:0] COND_SCAN_LAST = 3'd2;
   localparam logic [2:0] COND_COL_END   = 3'd3;
   localparam logic [2:0] COND_LAST_RANK = 3'd4;

   typedef struct packed {
      logic [1:0]      wait_sel;
      logic [2:0]      cond_sel;
      logic            scan_clr;
      logic            scan_en;
      logic            mark_en;
      logic            read_en;
      logic            send_en;
      logic            rank_adv;
      logic            msg_clr;
      logic [PC_W-1:0] tgt_true;
      logic [PC_W-1:0] tgt_false;
   } cstc_uword_type;

   typedef struct packed {
      logic req_fire;
      logic rsp_free;
      logic start;
      logic scan_last;
      logic col_end;
      logic last_rank;
   } cstc_cond_type;

   function automatic cstc_uword_type ucode_rom(input logic [PC_W-1:0] pc);
      cstc_uword_type w;
      w = '0;
      w.wait_sel  = WAIT_NONE;
      w.cond_sel  = COND_ALWAYS;
      case (pc)
         ST_LOAD: begin
            w.wait_sel  = WAIT_REQ;
            w.cond_sel  = COND_START;
            w.tgt_true  = ST_SCAN_INIT;
            w.tgt_false = ST_LOAD;
         end
         ST_SCAN_INIT: begin
            w.scan_clr  = 1'b1;
            w.tgt_true  = ST_SCAN;
            w.tgt_false = ST_SCAN;
         end
         ST_SCAN: begin
            w.scan_en   = 1'b1;
            w.cond_sel  = COND_SCAN_LAST;
            w.tgt_true  = ST_MARK;
            w.tgt_false = ST_SCAN;
         end
         ST_MARK: begin
            w.mark_en   = 1'b1;
            w.tgt_true  = ST_READ;
            w.tgt_false = ST_READ;
         end
         ST_READ: begin
            w.read_en   = 1'b1;
            w.tgt_true  = ST_SEND;
            w.tgt_false = ST_SEND;
         end
         ST_SEND: begin
            w.wait_sel  = WAIT_RSP;
            w.send_en   = 1'b1;
            w.cond_sel  = COND_COL_END;
            w.tgt_true  = ST_RANK;
            w.tgt_false = ST_READ;
         end
         ST_RANK: begin
            w.rank_adv  = 1'b1;
            w.cond_sel  = COND_LAST_RANK;
            w.tgt_true  = ST_DONE;
            w.tgt_false = ST_SCAN_INIT;
         end
         ST_DONE: begin
            w.msg_clr   = 1'b1;
            w.tgt_true  = ST_LOAD;
            w.tgt_false = ST_LOAD;
         end
         default: begin
            w.tgt_true  = ST_LOAD;
            w.tgt_false = ST_LOAD;
         end
      endcase
      return w;
   endfunction

   function automatic logic [7:0] swap_case(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'h61 && c <= 8'h7A) begin
         r = c - 8'h20;
      end else if (c >= 8'h41 && c <= 8'h5A) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

endpackage

// ===== sv/case_swap_columnar_transposition_unit.sv =====
// ----------------------------------------------------------------------------
// Case-swap columnar transposition unit
// Buffers a message with letter case swapped and emits its columnar
// transposition under a programmable key.
// ----------------------------------------------------------------------------
// Message beats are taken one per cycle while loading. After the end beat a
// microcoded sequencer emits the transposition: for each column it restarts the
// scan, steps through each key character in use to find the next smallest key
// character, selects that column, then for each output beat reads the buffer
// and loads the output register (waiting while the output stalls), and closes
// the column; a final step clears the message state.
// The next message is accepted only after the last output beat is loaded.
module case_swap_columnar_transposition_unit
   import cstc_pkg::*;
#(
   parameter int MAX_MESSAGE = MAX_MESSAGE_DEF,
   parameter int MAX_KEY     = MAX_KEY_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  cstc_req_type           req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output cstc_rsp_type           rsp_payload,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int AW = (MAX_MESSAGE > 1) ? $clog2(MAX_MESSAGE) : 1;
   localparam int CW = $clog2(MAX_MESSAGE + 1);
   localparam int KW = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;
   localparam int PW = $clog2(MAX_MESSAGE + MAX_KEY + 1);

   cstc_uword_type uword;
   cstc_cond_type  cond;

   logic [KEY_LEN_W-1:0] key_length_ff;
   logic [7:0]           key_ff [MAX_KEY];

   logic [7:0]    mem [MAX_MESSAGE];
   logic [7:0]    mem_rd_ff;
   logic          pad_ff;

   logic [CW-1:0] count_ff, count_in, count_after;
   logic          drop_ff, drop_in;

   logic [MAX_KEY-1:0] taken_ff;
   logic [KW-1:0]      idx_ff;
   logic [KW-1:0]      best_ff;
   logic [7:0]         best_key_ff;
   logic               best_vld_ff;
   logic [KW-1:0]      col_ff;
   logic [KW-1:0]      rank_ff;
   logic [PW-1:0]      row_base_ff;

   logic               rsp_valid_ff;
   cstc_rsp_type       rsp_ff;

   logic [KEY_LEN_W-1:0] wid, wid_m1;
   logic                 req_fire, keep, room, store_en, empty_end;
   logic                 rsp_free, send_go, better;
   logic [PW-1:0]        rb_next, pos;

   always_comb begin
      if (key_length_ff == '0) begin
         wid = KEY_LEN_W'(1);
      end else if (key_length_ff > KEY_LEN_W'(MAX_KEY)) begin
         wid = KEY_LEN_W'(MAX_KEY);
      end else begin
         wid = key_length_ff;
      end
   end
   assign wid_m1 = wid - KEY_LEN_W'(1);

   // Load side.
   assign req_ready   = (uword.wait_sel == WAIT_REQ);
   assign req_fire    = req_valid && req_ready;
   assign keep        = !(req_payload.message_end && req_payload.message_byte == NEWLINE_CHAR);
   assign room        = count_ff < CW'(MAX_MESSAGE);
   assign store_en    = req_fire && keep && room;
   assign count_after = count_ff + CW'(store_en);
   assign empty_end   = req_fire && req_payload.message_end && count_after == '0;

   always_comb begin
      count_in = count_after;
      drop_in  = drop_ff;
      if (req_fire && keep && !room) begin
         drop_in = 1'b1;
      end
      if (uword.msg_clr || empty_end) begin
         count_in = '0;
         drop_in  = 1'b0;
      end
   end

   // Datapath conditions.
   assign better  = !taken_ff[idx_ff] && (!best_vld_ff || key_ff[idx_ff] < best_key_ff);
   assign rb_next = row_base_ff + PW'(wid);
   assign pos     = row_base_ff + PW'(col_ff);
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign send_go  = uword.send_en && rsp_free;

   assign cond.req_fire  = req_fire;
   assign cond.rsp_free  = rsp_free;
   assign cond.start     = req_payload.message_end && count_after != '0;
   assign cond.scan_last = KEY_LEN_W'(idx_ff) == wid_m1;
   assign cond.col_end   = rb_next >= PW'(count_ff);
   assign cond.last_rank = KEY_LEN_W'(rank_ff) == wid_m1;

   cstc_useq u_seq (
      .clock (clock),
      .reset (reset),
      .cond  (cond),
      .uword (uword)
   );

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_length_ff <= KEY_LEN_W'(1);
      end else if (csr_we && csr_index == REG_KEY_LENGTH) begin
         key_length_ff <= csr_wdata[KEY_LEN_W-1:0];
      end
   end

   for (genvar j = 0; j < MAX_KEY; j++) begin : g_key
      always_ff @(posedge clock) begin
         if (reset) begin
            key_ff[j] <= '0;
         end else if (csr_we &&
                      csr_index == REG_KEY_CHARS_0_3 + CSR_INDEX_W'(j / CHARS_PER_WORD)) begin
            key_ff[j] <= csr_wdata[8*(j % CHARS_PER_WORD) +: 8];
         end
      end
   end

   // Message buffer.
   always_ff @(posedge clock) begin
      if (store_en) begin
         mem[count_ff[AW-1:0]] <= swap_case(req_payload.message_byte);
      end
      if (uword.read_en) begin
         pad_ff <= !(pos < PW'(count_ff));
         if (pos < PW'(count_ff)) begin
            mem_rd_ff <= mem[pos[AW-1:0]];
         end
      end
   end

   // Column selection and readout control.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         drop_ff     <= 1'b0;
         taken_ff    <= '0;
         idx_ff      <= '0;
         best_ff     <= '0;
         best_vld_ff <= 1'b0;
         col_ff      <= '0;
         rank_ff     <= '0;
         row_base_ff <= '0;
      end else begin
         count_ff <= count_in;
         drop_ff  <= drop_in;
         if (uword.scan_clr) begin
            idx_ff      <= '0;
            best_vld_ff <= 1'b0;
         end
         if (uword.scan_en) begin
            idx_ff <= idx_ff + KW'(1);
            if (better) begin
               best_ff     <= idx_ff;
               best_vld_ff <= 1'b1;
            end
         end
         if (uword.mark_en) begin
            col_ff            <= best_ff;
            taken_ff[best_ff] <= 1'b1;
            row_base_ff       <= '0;
         end
         if (send_go) begin
            row_base_ff <= rb_next;
         end
         if (uword.rank_adv) begin
            rank_ff <= rank_ff + KW'(1);
         end
         if (uword.msg_clr) begin
            taken_ff <= '0;
            rank_ff  <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (uword.scan_en && better) begin
         best_key_ff <= key_ff[idx_ff];
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (send_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (send_go) begin
         rsp_ff.cipher_byte <= pad_ff ? PAD_CHAR : mem_rd_ff;
         rsp_ff.run_end     <= cond.col_end && cond.last_rank;
         rsp_ff.overflowed  <= drop_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== sv/cstc_useq.sv =====
// ----------------------------------------------------------------------------
// Case-swap columnar transposition sequencer
// Step counter over the control store, with wait gating and two-way jumps.
// ----------------------------------------------------------------------------
module cstc_useq
   import cstc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  cstc_cond_type  cond,
   output cstc_uword_type uword
);

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   logic            go;
   logic            cond_val;

   assign uword = ucode_rom(pc_ff);

   always_comb begin
      case (uword.wait_sel)
         WAIT_NONE: go = 1'b1;
         WAIT_REQ:  go = cond.req_fire;
         WAIT_RSP:  go = cond.rsp_free;
         default:   go = 1'b1;
      endcase
      case (uword.cond_sel)
         COND_ALWAYS:    cond_val = 1'b1;
         COND_START:     cond_val = cond.start;
         COND_SCAN_LAST: cond_val = cond.scan_last;
         COND_COL_END:   cond_val = cond.col_end;
         COND_LAST_RANK: cond_val = cond.last_rank;
         default:        cond_val = 1'b1;
      endcase
      if (!go) begin
         pc_in = pc_ff;
      end else if (cond_val) begin
         pc_in = uword.tgt_true;
      end else begin
         pc_in = uword.tgt_false;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ST_LOAD;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// ===== verif/case_swap_columnar_transposition_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Case-swap columnar transposition unit testbench
// Streams messages into the unit under several keys and idling patterns and
// checks every ciphertext beat against a cycle-free prediction of the cipher.
// ----------------------------------------------------------------------------
module case_swap_columnar_transposition_unit_tb
   import cstc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_INDEX_W-1:0] REG_KEY_CHARS_12_15 = REG_KEY_CHARS_0_3 + 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_FIRST_UNUSED    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_LAST_UNUSED     = 3'd7;
   localparam int SETTLE_CYCLES  = 700;
   localparam int PHASE_COUNT    = 10;
   localparam int PHASE_BEATS    = 36;
   localparam int HOLD_OFF_CYCLES = 1500;

   class transposition_scoreboard;
      logic [KEY_LEN_W-1:0] key_len;
      logic [31:0]          key_words [4];
      logic [7:0]           plain_buf [MAX_MESSAGE_DEF];
      int unsigned          held;
      logic                 lost;
      cstc_rsp_type         cipher_q [$];

      function new();
         key_len = KEY_LEN_W'(1);
         foreach (key_words[k]) key_words[k] = '0;
         held = 0;
         lost = 1'b0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         if (idx == REG_KEY_LENGTH) begin
            key_len = value[KEY_LEN_W-1:0];
         end else if (idx >= REG_KEY_CHARS_0_3 && idx <= REG_KEY_CHARS_12_15) begin
            key_words[idx - REG_KEY_CHARS_0_3] = value;
         end
      endfunction

      function logic [7:0] flip_case(logic [7:0] c);
         logic [7:0] upper;
         upper = c & 8'hDF;
         if (upper >= "A" && upper <= "Z") begin
            return c ^ 8'h20;
         end
         return c;
      endfunction

      function logic [7:0] key_at(int unsigned col);
         return key_words[col / 4][(col % 4) * 8 +: 8];
      endfunction

      function void note_beat(cstc_req_type b);
         int unsigned width, rows, col, rank, r, i, pos;
         logic [MAX_KEY_DEF-1:0] used;
         cstc_rsp_type e;
         if (!(b.message_end && b.message_byte == NEWLINE_CHAR)) begin
            if (held < MAX_MESSAGE_DEF) begin
               plain_buf[held] = flip_case(b.message_byte);
               held++;
            end else begin
               lost = 1'b1;
            end
         end
         if (!b.message_end) return;
         if (key_len == 0) width = 1;
         else if (key_len > MAX_KEY_DEF) width = MAX_KEY_DEF;
         else width = key_len;
         rows = (held + width - 1) / width;
         used = '0;
         if (held != 0) begin
            for (rank = 0; rank < width; rank++) begin
               col = 0;
               while (used[col]) col++;
               for (i = col + 1; i < width; i++) begin
                  if (!used[i] && key_at(i) < key_at(col)) col = i;
               end
               used[col] = 1'b1;
               for (r = 0; r < rows; r++) begin
                  pos = r * width + col;
                  e.cipher_byte = (pos < held) ? plain_buf[pos] : PAD_CHAR;
                  e.run_end = 1'b0;
                  e.overflowed = lost;
                  cipher_q.push_back(e);
               end
            end
            cipher_q[cipher_q.size() - 1].run_end = 1'b1;
         end
         held = 0;
         lost = 1'b0;
      endfunction

      function string check_beat(cstc_rsp_type got);
         cstc_rsp_type want;
         string what;
         what = "";
         if (cipher_q.size() == 0) begin
            return $sformatf("unexpected beat byte=%02h end=%0b overflowed=%0b",
                             got.cipher_byte, got.run_end, got.overflowed);
         end
         want = cipher_q.pop_front();
         if (got.cipher_byte !== want.cipher_byte)
            what = {what, $sformatf(" cipher_byte %02h/%02h", got.cipher_byte, want.cipher_byte)};
         if (got.run_end !== want.run_end)
            what = {what, $sformatf(" run_end %0b/%0b", got.run_end, want.run_end)};
         if (got.overflowed !== want.overflowed)
            what = {what, $sformatf(" overflowed %0b/%0b", got.overflowed, want.overflowed)};
         return what;
      endfunction

      function int pending();
         return cipher_q.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   cstc_req_type           req_payload;
   logic                   rsp_valid;
   logic                   rsp_ready;
   cstc_rsp_type           rsp_payload;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   transposition_scoreboard sb;
   int mismatches = 0;
   int beats_sent = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_off_left = 0;

   logic [7:0] boundary_bytes [12] = '{8'h00, 8'hFF, 8'h40, 8'h41, 8'h5A, 8'h5B,
                                       8'h60, 8'h61, 8'h7A, 8'h7B, 8'h0A, 8'h0A};

   case_swap_columnar_transposition_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("TEST FAILED");
      $finish;
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 100) $display("mismatch at %0t ns:%s", $time, what);
   endtask

   task automatic send_beat(input logic [7:0] data, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{message_byte: data, message_end: last};
      do @(posedge clock); while (!req_ready);
      sb.note_beat(req_payload);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      sb.write_reg(idx, value);
      @(negedge clock);
   endtask

   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic program_key(input int phase);
      int unsigned len, k, j;
      logic [31:0] word;
      if (phase < 6) begin
         case (phase)
            0: len = 16;
            1: len = 1;
            2: len = 0;
            3: len = 31;
            4: len = 17;
            default: len = 16;
         endcase
      end else begin
         len = $urandom_range(15, 2);
      end
      csr_write(REG_KEY_LENGTH, {27'($urandom), 5'(len)});
      for (k = 0; k < 4; k++) begin
         case (phase % 3)
            0: word = $urandom;
            1: for (j = 0; j < 4; j++) word[j*8 +: 8] = 8'("A" + $urandom_range(2));
            default: word = 32'hFFFF_FFFF;
         endcase
         csr_write(3'(REG_KEY_CHARS_0_3 + k), word);
      end
      csr_write(3'($urandom_range(REG_LAST_UNUSED, REG_FIRST_UNUSED)), $urandom);
      csr_we <= 1'b0;
   endtask

   task automatic send_random_message();
      int unsigned len, pick, i;
      logic [7:0] data;
      pick = $urandom_range(99);
      if (pick < 5) len = 0;
      else if (pick < 15) len = $urandom_range(40, 33);
      else if (pick < 25) len = $urandom_range(32, 13);
      else len = $urandom_range(12, 1);
      if (len == 0) begin
         send_beat(NEWLINE_CHAR, 1'b1);
         return;
      end
      for (i = 0; i < len; i++) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            data = 8'("A" + $urandom_range(25));
            if ($urandom_range(1)) data = data ^ 8'h20;
         end else if (pick < 50) begin
            data = NEWLINE_CHAR;
         end else begin
            data = 8'($urandom);
         end
         if (i == len - 1 && $urandom_range(3) == 0) data = NEWLINE_CHAR;
         send_beat(data, i == len - 1);
      end
   endtask

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_left > 0) begin
            rsp_ready <= 1'b0;
            hold_off_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      string what;
      if (!reset && rsp_valid && rsp_ready) begin
         what = sb.check_beat(rsp_payload);
         if (what != "") report_mismatch(what);
      end
   end

   initial begin
      int phase, start;
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_beat("k", 1'b0);
      send_beat(8'hFF, 1'b1);
      drain_and_settle();

      csr_write(REG_KEY_LENGTH, 32'd4);
      csr_write(REG_KEY_CHARS_0_3, "ADBD");
      csr_write(REG_FIRST_UNUSED, '1);
      csr_we <= 1'b0;
      foreach (boundary_bytes[i]) send_beat(boundary_bytes[i], i == 11);
      send_beat(NEWLINE_CHAR, 1'b1);
      drain_and_settle();

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         program_key(phase);
         case (phase % 4)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 85;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 85;
            end
            default: begin
               send_idle_pct = 37;
               recv_stall_pct = 37;
            end
         endcase
         if (phase == 5) hold_off_left = HOLD_OFF_CYCLES;
         start = beats_sent;
         while (beats_sent - start < PHASE_BEATS) send_random_message();
         drain_and_settle();
      end

      if (mismatches == 0 && sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
